[design/pem_pkg.sv]
`timescale 1ns / 1ps
package pem_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int PIDX_W = 6;
    localparam int CFG_IDX_W = 8;
    localparam int SLOT_W = 6 * 32 + 16;

    localparam logic [CFG_IDX_W-1:0] CFG_AGE_RATE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_RATE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_INT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 8'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP_A, ST_PREP_D, ST_RD, ST_LD, ST_MUL_V, ST_MUL_P, ST_ADD,
        ST_RNG, ST_LMUL, ST_LSET, ST_WR, ST_SPAWN, ST_EM_RD, ST_EM_LD, ST_EM_WAIT
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } rng_ctl_t;

    function automatic logic signed [31:0] sat_s32(input logic signed [49:0] x);
        if (x > 50'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

[design/pem_store.sv]
`timescale 1ns / 1ps
module pem_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                     aclk,
    input  pem_pkg::mem_ctl_t        ctl,
    input  logic [AW-1:0]            addr,
    input  logic [pem_pkg::SLOT_W-1:0] wr_data,
    output logic [pem_pkg::SLOT_W-1:0] rd_data
);
    import pem_pkg::*;

    logic [SLOT_W-1:0] mem [DEPTH];
    logic [SLOT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/pem_rng.sv]
`timescale 1ns / 1ps
module pem_rng (
    input  logic              aclk,
    input  logic              aresetn,
    input  pem_pkg::rng_ctl_t ctl,
    input  logic [31:0]       seed,
    output logic [31:0]       state
);
    import pem_pkg::*;

    logic [31:0] state_reg;
    logic [31:0] s0, s1, s2, state_next;

    always_comb begin
        s0 = (state_reg == 32'd0) ? 32'd1 : state_reg;
        s1 = s0 ^ (s0 << 13);
        s2 = s1 ^ (s1 >> 17);
        state_next = s2 ^ (s2 << 5);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= 32'd1;
        end else if (ctl.load) begin
            state_reg <= seed;
        end else if (ctl.step) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

[design/particle_emitter_update_core.sv]
`timescale 1ns / 1ps
// Particle emitter: each request on s_ carries the frame time; every live particle is
// aged, dragged and moved (or respawned), one may be appended, then all live particles
// are sent on m_ in slot order, last set on the final one. Particle state sits in one
// single-port memory, one slot per word, processed one slot at a time. A tick runs a
// setup, then for each live particle a read, a load, three axes (or three launch draws
// when it is respawned) and a write back, then the spawn check and, if one is spawned,
// three launch draws and a write back, then each particle to emit is read, loaded and
// held on m_ until m_ready is high.
module particle_emitter_update_core #(
    parameter int MAX_PARTICLES = pem_pkg::MAX_PARTICLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [31:0]                     s_time_now,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pem_pkg::PIDX_W-1:0]      m_particle_index,
    output logic signed [31:0]              m_pos_x,
    output logic signed [31:0]              m_pos_y,
    output logic signed [31:0]              m_pos_z,
    output logic [15:0]                     m_age,
    output logic                            m_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import pem_pkg::*;

    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTICLES);

    state_t state_reg, state_next;

    logic [15:0] age_rate_reg, drag_rate_reg;
    logic [31:0] spawn_int_reg, seed_reg;
    logic signed [31:0] rise_reg;
    logic [30:0] spread_reg;

    logic [CNT_W-1:0] count_reg;
    logic [31:0] prev_time_reg, last_spawn_reg, now_reg, dt_reg;
    logic [31:0] age_inc_reg;
    logic [16:0] factor_reg;
    logic [IDX_W-1:0] k_reg;
    logic [1:0] j_reg;
    logic spawn_reg;

    logic signed [31:0] pos_w_reg [3];
    logic signed [31:0] vel_w_reg [3];
    logic [15:0] age_w_reg;
    logic signed [49:0] prod1_reg;
    logic signed [64:0] prod2_reg;

    logic m_valid_reg;
    logic [PIDX_W-1:0] m_idx_reg;
    logic signed [31:0] m_x_reg, m_y_reg, m_z_reg;
    logic [15:0] m_age_reg;
    logic m_last_reg;

    mem_ctl_t mem_ctl;
    rng_ctl_t rng_ctl;
    logic [IDX_W-1:0] mem_addr;
    logic [SLOT_W-1:0] mem_wdata, mem_rdata;
    logic [31:0] rng_state;

    logic [47:0] rate_prod;
    logic [32:0] age_sum;
    logic age_ok, j_last, k_last, spawn_go, em_last;
    logic [CNT_W-1:0] count_m1;
    logic signed [31:0] vnew, term;
    logic signed [17:0] centred;
    logic signed [49:0] pos_sum;
    logic signed [32:0] rise_sum;

    pem_store #(.DEPTH(MAX_PARTICLES), .AW(IDX_W)) u_store (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .addr    (mem_addr),
        .wr_data (mem_wdata),
        .rd_data (mem_rdata)
    );

    pem_rng u_rng (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rng_ctl),
        .seed    (cfg_data),
        .state   (rng_state)
    );

    always_comb begin
        rate_prod = dt_reg * ((state_reg == ST_PREP_A) ? age_rate_reg : drag_rate_reg);
        age_sum   = {17'd0, mem_rdata[15:0]} + {1'b0, age_inc_reg};
        age_ok    = (age_sum[32:16] == 17'd0);
        j_last    = (j_reg == 2'd2);
        count_m1  = count_reg - CNT_W'(1);
        k_last    = ({{(CNT_W-IDX_W){1'b0}}, k_reg} == count_m1);
        spawn_go  = (count_reg < MAX_CNT)
                    && (({1'b0, last_spawn_reg} + {1'b0, spawn_int_reg}) < {1'b0, now_reg});
        vnew      = prod1_reg[47:16];
        term      = prod1_reg[47:16];
        centred   = 18'sd32768 - $signed({2'b00, rng_state[31:16]});
        pos_sum   = {{18{pos_w_reg[j_reg][31]}}, pos_w_reg[j_reg]}
                    + {prod2_reg[64], prod2_reg[64:16]};
        rise_sum  = {rise_reg[31], rise_reg} + {term[31], term};
        em_last   = k_last;
        mem_wdata = {pos_w_reg[0], pos_w_reg[1], pos_w_reg[2],
                     vel_w_reg[0], vel_w_reg[1], vel_w_reg[2], age_w_reg};
        mem_addr  = k_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_PREP_A;
            ST_PREP_A:  state_next = ST_PREP_D;
            ST_PREP_D:  state_next = (count_reg == '0) ? ST_SPAWN : ST_RD;
            ST_RD:      state_next = ST_LD;
            ST_LD:      state_next = age_ok ? ST_MUL_V : ST_RNG;
            ST_MUL_V:   state_next = ST_MUL_P;
            ST_MUL_P:   state_next = ST_ADD;
            ST_ADD:     state_next = j_last ? ST_WR : ST_MUL_V;
            ST_RNG:     state_next = ST_LMUL;
            ST_LMUL:    state_next = ST_LSET;
            ST_LSET:    state_next = j_last ? ST_WR : ST_RNG;
            ST_WR: begin
                if (spawn_reg) begin
                    state_next = ST_EM_RD;
                end else if (k_last) begin
                    state_next = ST_SPAWN;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_SPAWN: begin
                if (spawn_go) begin
                    state_next = ST_RNG;
                end else if (count_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_EM_RD;
                end
            end
            ST_EM_RD:   state_next = ST_EM_LD;
            ST_EM_LD:   state_next = ST_EM_WAIT;
            ST_EM_WAIT: begin
                if (m_ready) state_next = m_last_reg ? ST_IDLE : ST_EM_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        mem_ctl.rd_en = (state_reg == ST_RD) || (state_reg == ST_EM_RD);
        mem_ctl.wr_en = (state_reg == ST_WR);
        rng_ctl.load  = cfg_valid && (cfg_index == CFG_SEED);
        rng_ctl.step  = (state_reg == ST_RNG);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            age_rate_reg   <= 16'd13107;
            drag_rate_reg  <= 16'd6554;
            spawn_int_reg  <= 32'd3277;
            rise_reg       <= 32'sd327680;
            spread_reg     <= 31'd131072;
            seed_reg       <= 32'd1;
            count_reg      <= '0;
            prev_time_reg  <= '0;
            last_spawn_reg <= '0;
            spawn_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_AGE_RATE:  age_rate_reg  <= cfg_data[15:0];
                    CFG_DRAG_RATE: drag_rate_reg <= cfg_data[15:0];
                    CFG_SPAWN_INT: spawn_int_reg <= cfg_data;
                    CFG_RISE:      rise_reg      <= cfg_data;
                    CFG_SPREAD:    spread_reg    <= cfg_data[30:0];
                    CFG_SEED:      seed_reg      <= cfg_data;
                    default:       ;
                endcase
            end
            if (state_reg == ST_IDLE && s_valid) begin
                prev_time_reg <= s_time_now;
            end
            if (state_reg == ST_SPAWN && spawn_go) begin
                spawn_reg <= 1'b1;
            end
            if (state_reg == ST_WR && spawn_reg) begin
                spawn_reg      <= 1'b0;
                count_reg      <= count_reg + CNT_W'(1);
                last_spawn_reg <= now_reg;
            end
            if (state_reg == ST_EM_LD) begin
                m_valid_reg <= 1'b1;
            end else if (state_reg == ST_EM_WAIT && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                now_reg <= s_time_now;
                dt_reg  <= (s_time_now >= prev_time_reg) ? s_time_now - prev_time_reg : '0;
            end
            ST_PREP_A: age_inc_reg <= rate_prod[47:16];
            ST_PREP_D: begin
                factor_reg <= (rate_prod[47:32] != 16'd0) ? 17'd0
                              : 17'h10000 - {1'b0, rate_prod[31:16]};
                k_reg      <= '0;
            end
            ST_LD: begin
                pos_w_reg[0] <= mem_rdata[207:176];
                pos_w_reg[1] <= mem_rdata[175:144];
                pos_w_reg[2] <= mem_rdata[143:112];
                vel_w_reg[0] <= mem_rdata[111:80];
                vel_w_reg[1] <= mem_rdata[79:48];
                vel_w_reg[2] <= mem_rdata[47:16];
                age_w_reg    <= age_sum[15:0];
                j_reg        <= 2'd0;
            end
            ST_MUL_V: prod1_reg <= vel_w_reg[j_reg] * $signed({1'b0, factor_reg});
            ST_MUL_P: begin
                vel_w_reg[j_reg] <= vnew;
                prod2_reg        <= vnew * $signed({1'b0, dt_reg});
            end
            ST_ADD: begin
                pos_w_reg[j_reg] <= sat_s32(pos_sum);
                j_reg            <= j_reg + 2'd1;
            end
            ST_LMUL: prod1_reg <= centred * $signed({1'b0, spread_reg});
            ST_LSET: begin
                vel_w_reg[j_reg] <= (j_reg == 2'd1)
                                    ? sat_s32({{17{rise_sum[32]}}, rise_sum}) : term;
                pos_w_reg[j_reg] <= '0;
                age_w_reg        <= '0;
                j_reg            <= j_reg + 2'd1;
            end
            ST_WR: begin
                if (spawn_reg) begin
                    k_reg <= '0;
                end else if (!k_last) begin
                    k_reg <= k_reg + IDX_W'(1);
                end
            end
            ST_SPAWN: begin
                if (spawn_go) begin
                    k_reg <= count_reg[IDX_W-1:0];
                    j_reg <= 2'd0;
                end else begin
                    k_reg <= '0;
                end
            end
            ST_EM_LD: begin
                m_idx_reg  <= PIDX_W'(k_reg);
                m_x_reg    <= mem_rdata[207:176];
                m_y_reg    <= mem_rdata[175:144];
                m_z_reg    <= mem_rdata[143:112];
                m_age_reg  <= mem_rdata[15:0];
                m_last_reg <= em_last;
            end
            ST_EM_WAIT: if (m_ready && !m_last_reg) k_reg <= k_reg + IDX_W'(1);
            default: ;
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_particle_index = m_idx_reg;
    assign m_pos_x          = m_x_reg;
    assign m_pos_y          = m_y_reg;
    assign m_pos_z          = m_z_reg;
    assign m_age            = m_age_reg;
    assign m_last           = m_last_reg;

    a_mvalid_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_EM_WAIT)
        else $error("result valid outside emit phase");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("request taken while a result is pending");
    a_mem_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("memory read and write in one cycle");
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("live count beyond capacity");
    a_seed_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        rng_ctl.load |=> rng_state == seed_reg)
        else $error("seed not loaded");

endmodule
